// File: hw/rtl/ssle_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ssle_pkg
// Shared sizes, codes and types of the sorted static list engine.
// ---------------------------------------------------------------------------
package ssle_pkg;

    // list geometry
    localparam int DEPTH  = 32;
    localparam int SLOT_W = $clog2(DEPTH);
    localparam int LINK_W = $clog2(DEPTH + 1);
    localparam logic [LINK_W-1:0] NIL = LINK_W'(DEPTH);

    // fixed field widths of the command and result ports
    localparam int CMD_W      = 3;
    localparam int KEY_W      = 32;
    localparam int STATUS_W   = 2;
    localparam int SLOT_OUT_W = 5;
    localparam int COUNT_W    = 6;

    // command codes
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd2;
    localparam logic [CMD_W-1:0] CMD_REINIT = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SIZE   = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DUP      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

    // command queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // decoded operation
    typedef enum logic [2:0] {
        OP_INS,
        OP_DEL,
        OP_SRCH,
        OP_REINIT,
        OP_SIZE,
        OP_NOP
    } t_op;

    typedef struct packed {
        t_op                     op;
        logic signed [KEY_W-1:0] key;
    } t_item;

    typedef struct packed {
        logic empty;
        logic full;
    } t_qstat;

endpackage

// File: hw/rtl/ssle_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ssle_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
module ssle_ram #(
    parameter int W = 32,
    parameter int D = 32
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/ssle_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ssle_front
// Command intake: takes a command transfer and decodes it into an operation.
// ---------------------------------------------------------------------------
module ssle_front (
    input  logic                             start,
    output logic                             busy,
    input  logic [ssle_pkg::CMD_W-1:0]       i_command,
    input  logic signed [ssle_pkg::KEY_W-1:0] i_key,
    input  ssle_pkg::t_qstat                 i_qstat,
    output logic                             o_push,
    output ssle_pkg::t_item                  o_item
);
    import ssle_pkg::*;

    t_op op;

    // hold off new commands while the queue is full
    assign busy   = i_qstat.full;
    assign o_push = start && !i_qstat.full;

    // command decode, unused codes become a no-op
    always_comb begin
        case (i_command)
            CMD_INSERT: op = OP_INS;
            CMD_DELETE: op = OP_DEL;
            CMD_SEARCH: op = OP_SRCH;
            CMD_REINIT: op = OP_REINIT;
            CMD_SIZE:   op = OP_SIZE;
            default:    op = OP_NOP;
        endcase
    end

    assign o_item.op  = op;
    assign o_item.key = i_key;

endmodule

// File: hw/rtl/ssle_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ssle_queue
// Short command queue that decouples intake from the list engine.
// ---------------------------------------------------------------------------
module ssle_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ssle_pkg::t_item   i_item,
    input  logic              i_pop,
    output ssle_pkg::t_item   o_item,
    output ssle_pkg::t_qstat  o_stat
);
    import ssle_pkg::*;

    t_item              r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wp, n_wp;
    logic [QPTR_W-1:0]  r_rp, n_rp;
    logic [QCNT_W-1:0]  r_cnt, n_cnt;
    logic               do_push;
    logic               do_pop;

    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.full  = (r_cnt == QCNT_W'(QDEPTH));
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_item       = r_mem[r_rp];

    // pointer and fill count update
    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wp = (r_wp == QPTR_W'(QDEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (do_pop) begin
            n_rp = (r_rp == QPTR_W'(QDEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

// File: hw/rtl/ssle_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ssle_back
// List engine: walks the linked slots, updates links and heads, and
// produces one result per command.
// ---------------------------------------------------------------------------
module ssle_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ssle_pkg::t_qstat                    i_qstat,
    input  ssle_pkg::t_item                     i_item,
    output logic                                o_pop,
    output logic                                o_valid,
    output logic [ssle_pkg::STATUS_W-1:0]       o_status,
    output logic [ssle_pkg::SLOT_OUT_W-1:0]     o_slot,
    output logic [ssle_pkg::COUNT_W-1:0]        o_count
);
    import ssle_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_WALK = 5'b00010,
        S_FREE = 5'b00100,
        S_WR1  = 5'b01000,
        S_WR2  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // control state
    logic [LINK_W-1:0]   r_head, n_head;
    logic [LINK_W-1:0]   r_free, n_free;
    logic [LINK_W-1:0]   r_count, n_count;
    logic [DEPTH-1:0]    r_lvld, n_lvld;
    logic                r_ovalid, n_ovalid;

    // per-command working registers
    t_op                 r_op, n_op;
    logic signed [KEY_W-1:0] r_key, n_key;
    logic [LINK_W-1:0]   r_cur, n_cur;
    logic [LINK_W-1:0]   r_prev, n_prev;
    logic [LINK_W-1:0]   r_step, n_step;
    logic [LINK_W-1:0]   r_nxt, n_nxt;
    logic [SLOT_W-1:0]   r_rd_addr;
    logic                r_rd_vld;
    logic [STATUS_W-1:0] r_ostatus, n_ostatus;
    logic [LINK_W-1:0]   r_oslot, n_oslot;
    logic [LINK_W-1:0]   r_ocount, n_ocount;

    // memory ports
    logic                    key_we;
    logic [SLOT_W-1:0]       key_waddr;
    logic signed [KEY_W-1:0] key_q;
    logic                    link_we;
    logic [SLOT_W-1:0]       link_waddr;
    logic [LINK_W-1:0]       link_wdata;
    logic [LINK_W-1:0]       link_q;
    logic [SLOT_W-1:0]       rd_addr;

    // walk decode
    logic [LINK_W-1:0]   link_eff;
    logic                cur_ok;
    logic                hit;
    logic                go_on;

    ssle_ram #(.W(KEY_W), .D(DEPTH)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (key_waddr),
        .i_wdata (r_key),
        .i_raddr (rd_addr),
        .o_rdata (key_q)
    );

    ssle_ram #(.W(LINK_W), .D(DEPTH)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_raddr (rd_addr),
        .o_rdata (link_q)
    );

    // a link never written since reset or reinit points to the next slot
    assign link_eff = r_rd_vld ? link_q : LINK_W'(r_rd_addr) + 1'b1;
    assign cur_ok   = (r_cur < LINK_W'(DEPTH));
    assign hit      = (key_q == r_key);
    assign go_on    = (r_op == OP_SRCH) ? !hit : (key_q < r_key);
    assign o_pop    = (r_state == S_IDLE) && !i_qstat.empty;

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_free     = r_free;
        n_count    = r_count;
        n_lvld     = r_lvld;
        n_op       = r_op;
        n_key      = r_key;
        n_cur      = r_cur;
        n_prev     = r_prev;
        n_step     = r_step;
        n_nxt      = r_nxt;
        n_ovalid   = 1'b0;
        n_ostatus  = ST_OK;
        n_oslot    = '0;
        n_ocount   = r_count;
        key_we     = 1'b0;
        key_waddr  = r_free[SLOT_W-1:0];
        link_we    = 1'b0;
        link_waddr = r_cur[SLOT_W-1:0];
        link_wdata = r_cur;
        rd_addr    = r_cur[SLOT_W-1:0];

        case (r_state)
            S_IDLE: begin
                if (!i_qstat.empty) begin
                    n_op   = i_item.op;
                    n_key  = i_item.key;
                    n_cur  = r_head;
                    n_prev = NIL;
                    n_step = '0;
                    rd_addr = r_head[SLOT_W-1:0];
                    case (i_item.op)
                        OP_INS: begin
                            if (r_free >= LINK_W'(DEPTH)) begin
                                n_ovalid  = 1'b1;
                                n_ostatus = ST_FULL;
                            end else begin
                                n_state = S_WALK;
                            end
                        end
                        OP_DEL, OP_SRCH: begin
                            n_state = S_WALK;
                        end
                        OP_REINIT: begin
                            n_lvld   = '0;
                            n_head   = NIL;
                            n_free   = '0;
                            n_count  = '0;
                            n_ocount = '0;
                            n_ovalid = 1'b1;
                        end
                        default: begin
                            n_ovalid = 1'b1;
                        end
                    endcase
                end
            end

            S_WALK: begin
                if (cur_ok && r_step != LINK_W'(DEPTH) && go_on) begin
                    // step to the next linked slot
                    n_prev  = r_cur;
                    n_cur   = link_eff;
                    n_step  = r_step + 1'b1;
                    rd_addr = link_eff[SLOT_W-1:0];
                end else begin
                    // walk ended: resolve the command
                    logic found;
                    found = cur_ok && r_step != LINK_W'(DEPTH) && hit;
                    case (r_op)
                        OP_SRCH: begin
                            n_ovalid  = 1'b1;
                            n_state   = S_IDLE;
                            n_ostatus = found ? ST_OK : ST_NOTFOUND;
                            n_oslot   = found ? r_cur : '0;
                        end
                        OP_DEL: begin
                            if (found) begin
                                n_nxt   = link_eff;
                                n_state = S_WR1;
                            end else begin
                                n_ovalid  = 1'b1;
                                n_ostatus = ST_NOTFOUND;
                                n_state   = S_IDLE;
                            end
                        end
                        default: begin
                            if (found) begin
                                n_ovalid  = 1'b1;
                                n_ostatus = ST_DUP;
                                n_state   = S_IDLE;
                            end else begin
                                if (!cur_ok || r_step == LINK_W'(DEPTH)) begin
                                    n_cur = NIL;
                                end
                                rd_addr = r_free[SLOT_W-1:0];
                                n_state = S_FREE;
                            end
                        end
                    endcase
                end
            end

            S_FREE: begin
                // new slot takes the key and links to the walk position
                key_we     = 1'b1;
                link_we    = 1'b1;
                link_waddr = r_free[SLOT_W-1:0];
                link_wdata = r_cur;
                n_free     = link_eff;
                n_cur      = r_free;
                n_state    = S_WR2;
            end

            S_WR1: begin
                // unlink the deleted slot
                if (r_prev >= LINK_W'(DEPTH)) begin
                    n_head = r_nxt;
                end else begin
                    link_we    = 1'b1;
                    link_waddr = r_prev[SLOT_W-1:0];
                    link_wdata = r_nxt;
                end
                n_state = S_WR2;
            end

            S_WR2: begin
                n_ovalid = 1'b1;
                n_oslot  = r_cur;
                n_state  = S_IDLE;
                if (r_op == OP_INS) begin
                    if (r_prev >= LINK_W'(DEPTH)) begin
                        n_head = r_cur;
                    end else begin
                        link_we    = 1'b1;
                        link_waddr = r_prev[SLOT_W-1:0];
                        link_wdata = r_cur;
                    end
                    n_count = r_count + 1'b1;
                end else begin
                    // released slot goes on top of the free chain
                    link_we    = 1'b1;
                    link_waddr = r_cur[SLOT_W-1:0];
                    link_wdata = r_free;
                    n_free     = r_cur;
                    if (r_count != '0) begin
                        n_count = r_count - 1'b1;
                    end
                end
                n_ocount = n_count;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (link_we) begin
            n_lvld[link_waddr] = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= NIL;
            r_free   <= '0;
            r_count  <= '0;
            r_lvld   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_free   <= n_free;
            r_count  <= n_count;
            r_lvld   <= n_lvld;
            r_ovalid <= n_ovalid;
        end
    end

    // working and result registers
    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_key     <= n_key;
        r_cur     <= n_cur;
        r_prev    <= n_prev;
        r_step    <= n_step;
        r_nxt     <= n_nxt;
        r_rd_addr <= rd_addr;
        r_rd_vld  <= r_lvld[rd_addr];
        r_ostatus <= n_ostatus;
        r_oslot   <= n_oslot;
        r_ocount  <= n_ocount;
    end

    assign o_valid  = r_ovalid;
    assign o_status = r_ostatus;
    assign o_slot   = SLOT_OUT_W'(r_oslot);
    assign o_count  = COUNT_W'(r_ocount);

endmodule

// File: hw/rtl/sorted_static_list_engine.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sorted_static_list_engine
// Sorted list of signed 32-bit keys in linked slots, with a LIFO free chain.
// ---------------------------------------------------------------------------
// Commands are taken when start is high and busy is low; busy rises only
// when the two-entry command queue is full. Each command gives exactly one
// result, shown for one cycle with o_valid high; the receiver must take it
// then. Results come back in command order. The time to a result is set
// by the link walk over the list entries it passes (at most DEPTH): one
// read of the link and key memories per entry, the next address taken
// straight from the registered link read. Reinitialize needs no clearing
// pass; the link memory carries a valid bit per slot.
// ---------------------------------------------------------------------------
module sorted_static_list_engine (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [ssle_pkg::CMD_W-1:0]           i_command,
    input  logic signed [ssle_pkg::KEY_W-1:0]    i_key,
    output logic                                 o_valid,
    output logic [ssle_pkg::STATUS_W-1:0]        o_status,
    output logic [ssle_pkg::SLOT_OUT_W-1:0]      o_slot,
    output logic [ssle_pkg::COUNT_W-1:0]         o_count
);
    import ssle_pkg::*;

    t_item  push_item;
    t_item  pop_item;
    t_qstat qstat;
    logic   push;
    logic   pop;

    // command intake
    ssle_front u_front (
        .start     (start),
        .busy      (busy),
        .i_command (i_command),
        .i_key     (i_key),
        .i_qstat   (qstat),
        .o_push    (push),
        .o_item    (push_item)
    );

    // decoupling queue
    ssle_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_item  (pop_item),
        .o_stat  (qstat)
    );

    // list engine
    ssle_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_qstat  (qstat),
        .i_item   (pop_item),
        .o_pop    (pop),
        .o_valid  (o_valid),
        .o_status (o_status),
        .o_slot   (o_slot),
        .o_count  (o_count)
    );

endmodule

// File: hw/rtl/ssle_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ssle_sva_checker
// Port-level checks of the sorted static list engine, bound to the top.
// ---------------------------------------------------------------------------
module ssle_sva_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    input  logic                                 busy,
    input  logic [ssle_pkg::CMD_W-1:0]           i_command,
    input  logic signed [ssle_pkg::KEY_W-1:0]    i_key,
    input  logic                                 o_valid,
    input  logic [ssle_pkg::STATUS_W-1:0]        o_status,
    input  logic [ssle_pkg::SLOT_OUT_W-1:0]      o_slot,
    input  logic [ssle_pkg::COUNT_W-1:0]         o_count
);
    import ssle_pkg::*;

    // a failed command reports slot zero
    a_fail_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_slot == '0))
        else $error("failed command reported a nonzero slot");

    // the count never exceeds the slot array
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_count <= COUNT_W'(DEPTH)))
        else $error("count above list depth");

    // a full list holds every slot
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_FULL) |-> (o_count == COUNT_W'(DEPTH)))
        else $error("list full reported with free slots");

    // reset drops any pending result and frees the intake
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !busy))
        else $error("result or busy right after reset");

endmodule

bind sorted_static_list_engine ssle_sva_checker u_ssle_sva_checker (.*);

// File: bench/ssle_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ssle_checker
// Watches the command and result ports of the sorted static list engine,
// keeps its own sorted linked list with a LIFO free chain, and checks every
// result transfer against the oldest predicted result.
// ---------------------------------------------------------------------------
module ssle_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic                               i_busy,
    input  logic [ssle_pkg::CMD_W-1:0]         i_command,
    input  logic signed [ssle_pkg::KEY_W-1:0]  i_key,
    input  logic                               i_valid,
    input  logic [ssle_pkg::STATUS_W-1:0]      i_status,
    input  logic [ssle_pkg::SLOT_OUT_W-1:0]    i_slot,
    input  logic [ssle_pkg::COUNT_W-1:0]       i_count,
    output int                                 o_fail_count,
    output int                                 o_pending
);
    import ssle_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [SLOT_OUT_W-1:0] slot;
        logic [COUNT_W-1:0]    count;
    } t_result;

    // shadow copy of the list engine
    logic signed [KEY_W-1:0] key_mem  [DEPTH];
    logic [LINK_W-1:0]       link_mem [DEPTH];
    logic [LINK_W-1:0]       head_ptr;
    logic [LINK_W-1:0]       free_ptr;
    logic [COUNT_W-1:0]      held;

    t_result pending_results[$];
    int      fail_total = 0;

    // chain every slot onto the free list, empty the key list
    task automatic rebuild_chains();
        for (int i = 0; i < DEPTH; i++) begin
            link_mem[i] = LINK_W'(i + 1);
        end
        head_ptr = NIL;
        free_ptr = '0;
        held     = '0;
    endtask

    // walk past entries below the key; cur is the first entry not below it
    task automatic find_position(input logic signed [KEY_W-1:0] key,
                                 output logic [LINK_W-1:0] prev,
                                 output logic [LINK_W-1:0] cur);
        int steps;
        steps = 0;
        prev  = NIL;
        cur   = head_ptr;
        while (cur < DEPTH && steps < DEPTH && key_mem[cur] < key) begin
            prev = cur;
            cur  = link_mem[cur];
            steps++;
        end
        if (steps >= DEPTH) cur = NIL;
    endtask

    // apply one command to the shadow list and form its result
    task automatic predict_result(input logic [CMD_W-1:0] cmd,
                                  input logic signed [KEY_W-1:0] key,
                                  output t_result res);
        logic [LINK_W-1:0] prev;
        logic [LINK_W-1:0] cur;
        logic [LINK_W-1:0] fresh;
        int                steps;
        res = '0;
        case (cmd)
            CMD_INSERT: begin
                // full is checked ahead of the duplicate test
                if (free_ptr >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    find_position(key, prev, cur);
                    if (cur < DEPTH && key_mem[cur] == key) begin
                        res.status = ST_DUP;
                    end else begin
                        fresh         = free_ptr;
                        free_ptr      = link_mem[fresh];
                        key_mem[fresh] = key;
                        if (prev >= DEPTH) begin
                            link_mem[fresh] = head_ptr;
                            head_ptr        = fresh;
                        end else begin
                            link_mem[fresh] = link_mem[prev];
                            link_mem[prev]  = fresh;
                        end
                        held++;
                        res.slot = fresh[SLOT_OUT_W-1:0];
                    end
                end
            end
            CMD_DELETE: begin
                find_position(key, prev, cur);
                if (cur >= DEPTH || key_mem[cur] != key) begin
                    res.status = ST_NOTFOUND;
                end else begin
                    if (prev >= DEPTH) head_ptr = link_mem[cur];
                    else               link_mem[prev] = link_mem[cur];
                    // released slot goes to the head of the free chain
                    link_mem[cur] = free_ptr;
                    free_ptr      = cur;
                    if (held > 0) held--;
                    res.slot = cur[SLOT_OUT_W-1:0];
                end
            end
            CMD_SEARCH: begin
                steps = 0;
                cur   = head_ptr;
                while (cur < DEPTH && steps < DEPTH && key_mem[cur] != key) begin
                    cur = link_mem[cur];
                    steps++;
                end
                if (cur < DEPTH && steps < DEPTH) res.slot = cur[SLOT_OUT_W-1:0];
                else                              res.status = ST_NOTFOUND;
            end
            CMD_REINIT: begin
                rebuild_chains();
            end
            default: begin
                // size query and spare codes leave the list alone
            end
        endcase
        res.count = held;
    endtask

    task automatic report_mismatch(input string what, input int exp_val, input int act_val);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_val, act_val);
        fail_total++;
    endtask

    // result check first, then prediction of the command taken at this edge
    always @(posedge i_clk) begin : monitor
        t_result oldest;
        t_result predicted;
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                key_mem[i] = '0;
            end
            rebuild_chains();
            pending_results.delete();
        end else begin
            if (i_valid) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %0d/%0d/%0d",
                             $time, i_status, i_slot, i_count);
                    fail_total++;
                end else begin
                    oldest = pending_results.pop_front();
                    if (i_status !== oldest.status) report_mismatch("status", oldest.status, i_status);
                    if (i_slot !== oldest.slot)     report_mismatch("slot", oldest.slot, i_slot);
                    if (i_count !== oldest.count)   report_mismatch("count", oldest.count, i_count);
                end
            end
            if (i_start && !i_busy) begin
                predict_result(i_command, i_key, predicted);
                pending_results.push_back(predicted);
            end
        end
        o_pending    <= pending_results.size();
        o_fail_count <= fail_total;
    end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the sorted static list engine: a directed pass
// over the corner cases, then random command streams over key pools of
// varied size, with random sender gaps; checking is done by ssle_checker.
// ---------------------------------------------------------------------------
module tb_top;
    import ssle_pkg::*;

    localparam int RANDOM_ITEMS   = 1600;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 100;

    localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           start;
    logic                           busy;
    logic [CMD_W-1:0]               i_command;
    logic signed [KEY_W-1:0]        i_key;
    logic                           o_valid;
    logic [STATUS_W-1:0]            o_status;
    logic [SLOT_OUT_W-1:0]          o_slot;
    logic [COUNT_W-1:0]             o_count;
    int                             fail_count;
    int                             pending;

    logic signed [KEY_W-1:0]        key_pool [64];
    int                             pool_size;

    sorted_static_list_engine uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_command (i_command),
        .i_key     (i_key),
        .o_valid   (o_valid),
        .o_status  (o_status),
        .o_slot    (o_slot),
        .o_count   (o_count)
    );

    ssle_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_command    (i_command),
        .i_key        (i_key),
        .i_valid      (o_valid),
        .i_status     (o_status),
        .i_slot       (o_slot),
        .i_count      (o_count),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // sender gap: mostly short, now and then long, none in burst mode
    function automatic int draw_gap(input bit burst);
        int pick;
        pick = $urandom_range(0, 99);
        if (burst)          return 0;
        else if (pick < 55) return 0;
        else if (pick < 90) return $urandom_range(1, 3);
        else if (pick < 98) return $urandom_range(4, 12);
        else                return $urandom_range(20, 80);
    endfunction

    // keys weighted toward the extremes and small values around zero
    function automatic logic signed [KEY_W-1:0] draw_key();
        case ($urandom_range(0, 9))
            0:       return KEY_MIN;
            1:       return KEY_MAX;
            2:       return KEY_W'($urandom_range(0, 16)) - KEY_W'(8);
            default: return KEY_W'($urandom);
        endcase
    endfunction

    // called just after a falling edge; returns at the falling edge after the transfer
    task automatic issue_command(input logic [CMD_W-1:0] cmd,
                                 input logic signed [KEY_W-1:0] key,
                                 input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start     <= 1'b1;
        i_command <= cmd;
        i_key     <= key;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    // stimulus and verdict
    initial begin : stimulus
        int                      sent;
        int                      chunk_len;
        int                      pick;
        bit                      burst;
        logic [CMD_W-1:0]        op;
        logic signed [KEY_W-1:0] arg;
        sent      = 0;
        i_rst_n   = 1'b0;
        start     = 1'b0;
        i_command = CMD_SIZE;
        i_key     = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty list, extremes, duplicates, head/middle/tail removal
        issue_command(CMD_SIZE,   '0,        draw_gap(1'b0));
        issue_command(CMD_SEARCH, '0,        draw_gap(1'b0));
        issue_command(CMD_DELETE, 32'sd5,    draw_gap(1'b0));
        issue_command(CMD_INSERT, '0,        draw_gap(1'b0));
        issue_command(CMD_INSERT, KEY_MIN,   draw_gap(1'b0));
        issue_command(CMD_INSERT, KEY_MAX,   draw_gap(1'b0));
        issue_command(CMD_INSERT, -32'sd1,   draw_gap(1'b0));
        issue_command(CMD_INSERT, 32'sd1,    draw_gap(1'b0));
        issue_command(CMD_INSERT, KEY_MAX,   draw_gap(1'b0));
        issue_command(CMD_INSERT, KEY_MIN,   draw_gap(1'b0));
        issue_command(CMD_SEARCH, KEY_MIN,   draw_gap(1'b0));
        issue_command(CMD_SEARCH, KEY_MAX,   draw_gap(1'b0));
        issue_command(CMD_SEARCH, 32'sd2,    draw_gap(1'b0));
        issue_command(CMD_DELETE, KEY_MIN,   draw_gap(1'b0));
        issue_command(CMD_DELETE, '0,        draw_gap(1'b0));
        issue_command(CMD_DELETE, KEY_MAX,   draw_gap(1'b0));
        issue_command(CMD_DELETE, KEY_MAX,   draw_gap(1'b0));
        issue_command(CMD_INSERT, 32'sd7,    draw_gap(1'b0));
        for (int c = CMD_SPARE_FIRST; c <= CMD_SPARE_LAST; c++) begin
            issue_command(CMD_W'(c), -32'sd1, draw_gap(1'b0));
        end
        issue_command(CMD_REINIT, KEY_MAX,   draw_gap(1'b0));
        issue_command(CMD_SIZE,   KEY_MIN,   draw_gap(1'b0));
        issue_command(CMD_SEARCH, -32'sd1,   draw_gap(1'b0));
        issue_command(CMD_INSERT, 32'sd42,   draw_gap(1'b0));

        // random: chunks over a fresh key pool so fills, duplicates and hits occur
        while (sent < RANDOM_ITEMS) begin
            chunk_len = $urandom_range(60, 240);
            case ($urandom_range(0, 4))
                0:       pool_size = 3;
                1:       pool_size = 8;
                2:       pool_size = 24;
                3:       pool_size = 40;
                default: pool_size = 64;
            endcase
            for (int k = 0; k < pool_size; k++) begin
                key_pool[k] = draw_key();
            end
            burst = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 1) == 1) begin
                issue_command(CMD_REINIT, KEY_W'($urandom), draw_gap(burst));
                sent++;
            end
            repeat (chunk_len) begin
                pick = $urandom_range(0, 99);
                arg  = key_pool[$urandom_range(0, pool_size - 1)];
                if (pick < 48)      op = CMD_INSERT;
                else if (pick < 70) op = CMD_DELETE;
                else if (pick < 88) op = CMD_SEARCH;
                else if (pick < 94) begin
                    // noise: arbitrary key, not drawn from the pool
                    case ($urandom_range(0, 2))
                        0:       op = CMD_INSERT;
                        1:       op = CMD_DELETE;
                        default: op = CMD_SEARCH;
                    endcase
                    arg = KEY_W'($urandom);
                end
                else if (pick < 98) op = CMD_SIZE;
                else                op = CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
                issue_command(op, arg, draw_gap(burst));
                if (op <= CMD_SIZE) sent++;
            end
        end
        start <= 1'b0;

        // drain outstanding results, then allow for stray late ones
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // watchdog on cycles with no transfer on either side
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (start && !busy) || o_valid) idle_cycles = 0;
            else                                         idle_cycles++;
        end
        $display("%0t: watchdog expired with %0d results outstanding", $time, pending);
        $display("status: fail");
        $finish;
    end

endmodule
